>>> rtl/core/assert_macros.svh
// Assertion macros for the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbcw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CBCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbcw assertion failed");

`endif

>>> rtl/core/cbcw_pkg.sv
`default_nettype none

package cbcw_pkg;

    localparam int ADDR_W    = 15;
    localparam int DATA_W    = 8;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int CLK_SEL_W  = 4;
    localparam int KIND_W     = 3;

    localparam logic [KIND_W-1:0] MAPPER_MBC1       = 3'd0;
    localparam logic [KIND_W-1:0] MAPPER_MBC2       = 3'd1;
    localparam logic [KIND_W-1:0] MAPPER_MBC3       = 3'd2;
    localparam logic [KIND_W-1:0] MAPPER_MBC5       = 3'd3;
    localparam logic [KIND_W-1:0] MAPPER_MBC7       = 3'd4;
    localparam logic [KIND_W-1:0] MAPPER_IR_CART    = 3'd5;
    localparam logic [KIND_W-1:0] MAPPER_CLOCK_CART = 3'd6;

    localparam logic [ADDR_W-1:0] ADDR_ENABLE_END = 15'h1FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROM_LO_END = 15'h2FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROM_END    = 15'h3FFF;
    localparam logic [ADDR_W-1:0] ADDR_RAM_END    = 15'h5FFF;

    localparam logic [3:0]        RAM_ENABLE_CODE  = 4'hA;
    localparam logic [DATA_W-1:0] SECOND_EN_CODE   = 8'h40;
    localparam logic [DATA_W-1:0] MBC3_RAM_MAX     = 8'h03;
    localparam logic [DATA_W-1:0] MBC3_CLK_MIN     = 8'h08;
    localparam logic [DATA_W-1:0] MBC3_CLK_MAX     = 8'h0C;
    localparam int                MBC2_SELECT_BIT  = 8;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_sel;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_en;
        logic                  second_en;
        logic                  mbc1_mode;
        logic [CLK_SEL_W-1:0]  clk_sel;
    } t_bank_state;

endpackage

`default_nettype wire

>>> rtl/core/cbcw_if.sv
`default_nettype none

interface cbcw_wr_if;
    logic                           valid;
    logic                           ready;
    logic [cbcw_pkg::ADDR_W-1:0]    bus_address;
    logic [cbcw_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output bus_address, output write_data, input ready);
    modport sink   (input valid, input bus_address, input write_data, output ready);
endinterface

interface cbcw_res_if;
    logic                               valid;
    logic                               ready;
    logic [cbcw_pkg::ROM_BANK_W-1:0]    rom_bank_now;
    logic [cbcw_pkg::RAM_BANK_W-1:0]    ram_bank_now;
    logic                               ram_enabled;
    logic                               second_ram_enabled;
    logic                               ram_banking_mode;
    logic [cbcw_pkg::CLK_SEL_W-1:0]     clock_register_select;

    modport source (output valid, output rom_bank_now, output ram_bank_now,
                    output ram_enabled, output second_ram_enabled,
                    output ram_banking_mode, output clock_register_select,
                    input ready);
    modport sink   (input valid, input rom_bank_now, input ram_bank_now,
                    input ram_enabled, input second_ram_enabled,
                    input ram_banking_mode, input clock_register_select,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/cartridge_bank_controller_write.sv
// Channel   Dir  Handshake          Payload
// i_wr      in   valid/ready        bus_address[14:0], write_data[7:0]
// o_res     out  valid/ready        bank register snapshot after the write
// apb       in   psel/penable/pwr   mapper_kind at byte address 0
//
// Each item passes through the input register and then the result register.
// A new item is accepted every cycle while results are taken, so throughput is one item
// per clock, and a result is valid once its item moves on from the input register.
// The bank registers themselves form the result payload and change only when a result loads.
// When the result is stalled, one item waits in the input register and then ready drops.
// Synchronous active-low reset returns the bank registers and mapper kind to their defaults.
`default_nettype none
`include "assert_macros.svh"

module cartridge_bank_controller_write_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cbcw_wr_if.sink         i_wr,
    cbcw_res_if.source      o_res,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [cbcw_pkg::KIND_W-1:0] r_kind;
    logic                        r_s1_valid;
    logic [cbcw_pkg::ADDR_W-1:0] r_addr;
    logic [cbcw_pkg::DATA_W-1:0] r_data;
    logic                        r_out_valid;
    cbcw_pkg::t_bank_state       r_state;
    cbcw_pkg::t_bank_state       n_state;
    logic                        s1_advance;
    logic                        in_accept;
    logic                        enable_bit;
    logic [4:0]                  low5;
    logic [3:0]                  low4;
    logic [5:0]                  low6;
    logic [6:0]                  low7;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, r_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= cbcw_pkg::MAPPER_MBC1;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_kind <= pwdata[cbcw_pkg::KIND_W-1:0];
        end
    end

    assign s1_advance = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_wr.ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_wr.valid && i_wr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_wr.ready) begin
            r_s1_valid <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr <= i_wr.bus_address;
            r_data <= i_wr.write_data;
        end
    end

    assign enable_bit = (r_data[3:0] == cbcw_pkg::RAM_ENABLE_CODE);
    assign low4 = (r_data[3:0] == 4'd0) ? 4'd1 : r_data[3:0];
    assign low5 = (r_data[4:0] == 5'd0) ? 5'd1 : r_data[4:0];
    assign low6 = (r_data[5:0] == 6'd0) ? 6'd1 : r_data[5:0];
    assign low7 = (r_data[6:0] == 7'd0) ? 7'd1 : r_data[6:0];

    always_comb begin
        n_state = r_state;
        case (r_kind)
            cbcw_pkg::MAPPER_MBC1: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    if (!r_state.mbc1_mode) begin
                        n_state.rom_sel = {2'b00, r_state.ram_bank[1:0], low5};
                    end else begin
                        n_state.rom_sel = {4'b0000, low5};
                    end
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    n_state.ram_bank = {2'b00, r_data[1:0]};
                    if (!r_state.mbc1_mode) begin
                        n_state.rom_sel = {2'b00, r_data[1:0], r_state.rom_sel[4:0]};
                    end
                end else begin
                    n_state.mbc1_mode = r_data[0];
                    if (!r_data[0]) begin
                        n_state.rom_sel = {2'b00, r_state.ram_bank[1:0],
                                           r_state.rom_sel[4:0]};
                    end
                end
            end
            cbcw_pkg::MAPPER_MBC2: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    if (!r_addr[cbcw_pkg::MBC2_SELECT_BIT]) begin
                        n_state.ram_en = enable_bit;
                    end
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    if (r_addr[cbcw_pkg::MBC2_SELECT_BIT]) begin
                        n_state.rom_sel = {5'd0, low4};
                    end
                end
            end
            cbcw_pkg::MAPPER_MBC3: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    n_state.rom_sel = {2'b00, low7};
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    if (r_data <= cbcw_pkg::MBC3_RAM_MAX) begin
                        n_state.ram_bank = {2'b00, r_data[1:0]};
                        n_state.clk_sel  = 4'd0;
                    end else if (r_data >= cbcw_pkg::MBC3_CLK_MIN &&
                                 r_data <= cbcw_pkg::MBC3_CLK_MAX) begin
                        n_state.clk_sel  = r_data[3:0];
                        n_state.ram_bank = 4'd0;
                    end else begin
                        n_state.clk_sel  = 4'd0;
                        n_state.ram_bank = 4'd0;
                    end
                end
            end
            cbcw_pkg::MAPPER_MBC5: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_LO_END) begin
                    n_state.rom_sel = {r_state.rom_sel[8], r_data};
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    n_state.rom_sel = {r_data[0], r_state.rom_sel[7:0]};
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    n_state.ram_bank = r_data[3:0];
                end
            end
            cbcw_pkg::MAPPER_MBC7: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    n_state.rom_sel = (r_data == 8'd0) ? cbcw_pkg::ROM_BANK_RESET
                                                       : {1'b0, r_data};
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    n_state.second_en = (r_data == cbcw_pkg::SECOND_EN_CODE);
                end
            end
            cbcw_pkg::MAPPER_IR_CART: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    n_state.rom_sel = {3'b000, low6};
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    n_state.ram_bank = {2'b00, r_data[1:0]};
                end
            end
            cbcw_pkg::MAPPER_CLOCK_CART: begin
                if (r_addr <= cbcw_pkg::ADDR_ENABLE_END) begin
                    n_state.ram_en = enable_bit;
                end else if (r_addr <= cbcw_pkg::ADDR_ROM_END) begin
                    n_state.rom_sel = {2'b00, r_data[6:0]};
                end else if (r_addr <= cbcw_pkg::ADDR_RAM_END) begin
                    n_state.ram_bank = {2'b00, r_data[1:0]};
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_sel   <= cbcw_pkg::ROM_BANK_RESET;
            r_state.ram_bank  <= '0;
            r_state.ram_en    <= 1'b0;
            r_state.second_en <= 1'b0;
            r_state.mbc1_mode <= 1'b0;
            r_state.clk_sel   <= '0;
        end else if (s1_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid                 = r_out_valid;
    assign o_res.rom_bank_now          = r_state.rom_sel;
    assign o_res.ram_bank_now          = r_state.ram_bank;
    assign o_res.ram_enabled           = r_state.ram_en;
    assign o_res.second_ram_enabled    = r_state.second_en;
    assign o_res.ram_banking_mode      = r_state.mbc1_mode;
    assign o_res.clock_register_select = r_state.clk_sel;

    `CBCW_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, in_accept, r_s1_valid)
    `CBCW_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, s1_advance, r_out_valid)
    `CBCW_ASSERT_NEXT(a_waiting_item_kept, i_clk, i_rst_n, r_s1_valid && !s1_advance, r_s1_valid && $stable(r_addr))
    `CBCW_ASSERT_NEXT(a_stalled_state_held, i_clk, i_rst_n, r_out_valid && !o_res.ready, $stable(r_state))

endmodule

`default_nettype wire
